@@ design/acsp_pkg.sv @@
// Shared constants for the aging slot replacement policy.
package acsp_pkg;

    // Default slot count and stored key width.
    localparam int SLOTS_DEF    = 16;
    localparam int KEY_BITS_DEF = 32;

    // Fixed widths of the item fields.
    localparam int LOOKUP_KEY_W = 32;
    localparam int SLOT_FIELD_W = 4;

endpackage

@@ design/acsp_policy.sv @@
// Combinational lookup, victim choice and age update for one item.
module acsp_policy
    import acsp_pkg::*;
#(
    parameter int SLOTS    = SLOTS_DEF,
    parameter int KEY_BITS = KEY_BITS_DEF,
    parameter int SLOT_W   = $clog2(SLOTS)
) (
    input  logic [KEY_BITS-1:0]             i_key,
    input  logic [SLOTS-1:0][KEY_BITS-1:0]  i_keys,
    input  logic [SLOTS-1:0][SLOTS-1:0]     i_ages,
    output logic                            o_hit,
    output logic [SLOT_W-1:0]               o_idx,
    output logic [SLOTS-1:0][SLOTS-1:0]     o_ages
);

    localparam logic [SLOTS-1:0] TOP_AGE = {1'b1, {(SLOTS-1){1'b0}}};

    logic [SLOTS-1:0]              match;
    logic [SLOTS-1:0]              zero;
    logic [SLOTS-1:0]              is_min;
    logic [SLOTS-1:0][SLOTS-1:0]   half;
    logic [SLOT_W-1:0]             found_idx;
    logic [SLOT_W-1:0]             zero_idx;
    logic [SLOT_W-1:0]             min_idx;
    logic [SLOT_W-1:0]             victim;
    logic [SLOTS-1:0]              own;

    always_comb begin
        for (int i = 0; i < SLOTS; i++) begin
            match[i] = (i_keys[i] == i_key);
            half[i]  = i_ages[i] >> 1;
            zero[i]  = (half[i] == '0);
            is_min[i] = 1'b1;
            for (int j = 0; j < SLOTS; j++) begin
                if (half[i] > half[j]) begin
                    is_min[i] = 1'b0;
                end
            end
        end
    end

    // The lowest matching slot is the hit; the highest slot whose halved age is zero (or else least) is the victim.
    always_comb begin
        found_idx = '0;
        for (int i = SLOTS - 1; i >= 0; i--) begin
            if (match[i]) begin
                found_idx = SLOT_W'(i);
            end
        end
        zero_idx = '0;
        min_idx  = '0;
        for (int i = 0; i < SLOTS; i++) begin
            if (zero[i]) begin
                zero_idx = SLOT_W'(i);
            end
            if (is_min[i]) begin
                min_idx = SLOT_W'(i);
            end
        end
    end

    assign o_hit  = |match;
    assign own    = i_ages[found_idx];
    assign victim = (|zero) ? zero_idx : min_idx;
    assign o_idx  = o_hit ? found_idx : victim;

    always_comb begin
        o_ages = i_ages;
        if (o_hit) begin
            if (own != TOP_AGE) begin
                for (int i = 0; i < SLOTS; i++) begin
                    if (i_ages[i] > own) begin
                        o_ages[i] = half[i];
                    end
                end
                o_ages[found_idx] = TOP_AGE;
            end
        end else begin
            o_ages         = half;
            o_ages[victim] = TOP_AGE;
        end
    end

endmodule

@@ design/aging_cache_slot_policy_top.sv @@
// Top level of the aging slot replacement policy: handshakes, slot state and result register.
//
//   channel | direction | handshake                | payload
//   --------+-----------+--------------------------+----------------------
//   in      | input     | i_in_valid / o_in_ready  | i_lookup_key
//   out     | output    | o_out_valid / i_out_ready| o_hit, o_slot
//
// One item is taken per cycle while the result register is not stalled. An accepted
// item is held in the input register; the lookup, victim choice and age update then
// run in one pass of logic, and the result is loaded into the result register when
// the item advances.
// Reset clears all keys and ages to zero and empties both registers.
// A stalled result register holds the input register, which then stalls the input.
module aging_cache_slot_policy_top
    import acsp_pkg::*;
#(
    parameter int SLOTS    = SLOTS_DEF,
    parameter int KEY_BITS = KEY_BITS_DEF
) (
    input  logic                    i_clk,
    input  logic                    i_rst_n,
    input  logic                    i_in_valid,
    output logic                    o_in_ready,
    input  logic [LOOKUP_KEY_W-1:0] i_lookup_key,
    output logic                    o_out_valid,
    input  logic                    i_out_ready,
    output logic                    o_hit,
    output logic [SLOT_FIELD_W-1:0] o_slot
);

    localparam int SLOT_W = $clog2(SLOTS);

    // Input stage.
    logic                    r_in_valid;
    logic [LOOKUP_KEY_W-1:0] r_lookup_key;

    // Slot state: keys and aging words.
    logic [SLOTS-1:0][KEY_BITS-1:0] r_keys;
    logic [SLOTS-1:0][SLOTS-1:0]    r_ages;

    // Result stage.
    logic                    r_out_valid;
    logic                    r_hit;
    logic [SLOT_FIELD_W-1:0] r_slot;

    logic                              advance;
    logic [KEY_BITS-1:0]               key_ext;
    logic [KEY_BITS+LOOKUP_KEY_W-1:0]  key_wide;
    logic [SLOT_W+SLOT_FIELD_W-1:0]    slot_wide;
    logic                              n_hit;
    logic [SLOT_W-1:0]                 n_idx;
    logic [SLOTS-1:0][SLOTS-1:0]       n_ages;

    // The item in the input register moves on whenever the result register is free or is drained.
    assign advance    = r_in_valid && (!r_out_valid || i_out_ready);
    assign o_in_ready = !r_in_valid || advance;

    // Only the low KEY_BITS bits of the lookup key are compared; narrower lookup keys are zero-extended.
    assign key_wide  = {{KEY_BITS{1'b0}}, r_lookup_key};
    assign key_ext   = key_wide[KEY_BITS-1:0];
    assign slot_wide = {{SLOT_FIELD_W{1'b0}}, n_idx};

    acsp_policy #(
        .SLOTS    (SLOTS),
        .KEY_BITS (KEY_BITS),
        .SLOT_W   (SLOT_W)
    ) u_policy (
        .i_key  (key_ext),
        .i_keys (r_keys),
        .i_ages (r_ages),
        .o_hit  (n_hit),
        .o_idx  (n_idx),
        .o_ages (n_ages)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid  <= 1'b0;
            r_out_valid <= 1'b0;
            r_keys      <= '0;
            r_ages      <= '0;
        end else begin
            if (o_in_ready) begin
                r_in_valid <= i_in_valid;
            end
            if (advance) begin
                r_out_valid <= 1'b1;
                r_ages      <= n_ages;
                // A miss loads the key into the victim slot.
                if (!n_hit) begin
                    r_keys[n_idx] <= key_ext;
                end
            end else if (i_out_ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    // Payload registers carry no reset.
    always_ff @(posedge i_clk) begin
        if (o_in_ready && i_in_valid) begin
            r_lookup_key <= i_lookup_key;
        end
        if (advance) begin
            r_hit  <= n_hit;
            r_slot <= slot_wide[SLOT_FIELD_W-1:0];
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_hit       = r_hit;
    assign o_slot      = r_slot;

endmodule
